@@ sv/qats_pkg.sv @@
// ----------------------------------------------------------------------------
// qats_pkg
// Shared constants, register codes and payload types of the quote-aware
// token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package qats_pkg;

    localparam int MAX_PAIRS      = 8;
    localparam int MAX_SEPARATORS = 8;
    localparam int DEPTH_W        = 8;
    localparam int COUNT_W        = 16;
    localparam int CHAR_W         = 8;
    localparam int PCNT_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_OPEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_CLOSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_CHARS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd5;

    typedef logic [MAX_PAIRS-1:0][DEPTH_W-1:0]     t_depth_vec;
    typedef logic [MAX_PAIRS-1:0][CHAR_W-1:0]      t_pair_chars;
    typedef logic [MAX_SEPARATORS-1:0][CHAR_W-1:0] t_sep_chars;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              first_of_string;
    } t_in_item;

    typedef struct packed {
        logic               inhibited;
        logic               is_separator;
        logic               word_start;
        logic [COUNT_W-1:0] word_total;
        logic               target_hit;
        logic [COUNT_W-1:0] char_position;
    } t_out_item;

    // Result of the pair table for one character.
    typedef struct packed {
        t_depth_vec depth;
        logic       inhibited;
    } t_pair_res;

endpackage

`default_nettype wire

@@ sv/qats_in_if.sv @@
// ----------------------------------------------------------------------------
// qats_in_if
// Valid/ready channel carrying one input character word.
// ----------------------------------------------------------------------------
`default_nettype none

interface qats_in_if;
    import qats_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/qats_out_if.sv @@
// ----------------------------------------------------------------------------
// qats_out_if
// Valid/ready channel carrying one scan result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface qats_out_if;
    import qats_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/qats_pair_logic.sv @@
// ----------------------------------------------------------------------------
// qats_pair_logic
// Inhibitor pair table: next nesting depths and the inhibit decision for one
// character, all pairs evaluated in parallel with priority.
// ----------------------------------------------------------------------------
`default_nettype none

module qats_pair_logic
    import qats_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_escaped,
    input  wire t_depth_vec        i_depth,
    input  wire t_pair_chars       i_open,
    input  wire t_pair_chars       i_close,
    input  wire logic [PCNT_W-1:0] i_pair_count,
    output t_pair_res              o_res
);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    logic [MAX_PAIRS-1:0] used;
    logic [MAX_PAIRS-1:0] active;
    logic [MAX_PAIRS-1:0] sel;
    logic [MAX_PAIRS-1:0] is_open;
    logic [MAX_PAIRS-1:0] is_close;
    logic [MAX_PAIRS-1:0] is_toggle;
    t_depth_vec           inc_d;
    t_depth_vec           dec_d;
    t_depth_vec           nd;

    always_comb begin
        for (int k = 0; k < MAX_PAIRS; k++) begin
            used[k]      = i_pair_count > PCNT_W'(k);
            active[k]    = used[k] && (i_depth[k] != '0);
            is_open[k]   = i_open[k] == i_char;
            is_close[k]  = i_close[k] == i_char;
            is_toggle[k] = is_open[k] && (i_open[k] == i_close[k]) && !i_escaped;
            inc_d[k]     = (i_depth[k] == DEPTH_MAX) ? i_depth[k] : i_depth[k] + DEPTH_ONE;
            dec_d[k]     = (i_depth[k] == DEPTH_MIN) ? i_depth[k] : i_depth[k] - DEPTH_ONE;
        end
    end

    // One-hot select of the lowest active pair.
    always_comb begin
        logic found;
        found = 1'b0;
        sel   = '0;
        for (int k = 0; k < MAX_PAIRS; k++) begin
            sel[k] = active[k] && !found;
            found  = found || active[k];
        end
    end

    always_comb begin
        logic opened;
        logic inh_act;
        logic inh_idle;
        opened   = 1'b0;
        inh_act  = 1'b0;
        inh_idle = 1'b0;
        nd       = i_depth;
        if (|active) begin
            // Only the first open region sees the character.
            for (int k = 0; k < MAX_PAIRS; k++) begin
                if (sel[k]) begin
                    if (is_toggle[k]) begin
                        nd[k]   = '0;
                        inh_act = 1'b0;
                    end else if (is_open[k]) begin
                        nd[k]   = inc_d[k];
                        inh_act = inc_d[k] != '0;
                    end else if (is_close[k]) begin
                        nd[k]   = dec_d[k];
                        inh_act = 1'b1;
                    end else begin
                        inh_act = 1'b1;
                    end
                end
            end
        end else begin
            // No region open: every pair in use updates.
            for (int k = 0; k < MAX_PAIRS; k++) begin
                if (used[k]) begin
                    if (is_toggle[k]) begin
                        nd[k]  = (i_depth[k] == '0) ? DEPTH_ONE : '0;
                        opened = i_depth[k] == '0;
                    end else if (is_open[k]) begin
                        nd[k]  = inc_d[k];
                        opened = 1'b1;
                    end else if (is_close[k]) begin
                        nd[k]  = dec_d[k];
                    end
                end
            end
            for (int k = 0; k < MAX_PAIRS; k++) begin
                if (used[k] && (nd[k] != '0) && ((nd[k] != DEPTH_ONE) || !opened)) begin
                    inh_idle = 1'b1;
                end
            end
        end
        o_res.depth     = nd;
        o_res.inhibited = (|active) ? inh_act : inh_idle;
    end

endmodule

`default_nettype wire

@@ sv/quote_aware_token_scanner.sv @@
// ----------------------------------------------------------------------------
// quote_aware_token_scanner
// Scans a byte stream one character per word, tracking quoted and bracketed
// regions, separators, word starts and the first uninhibited target hit.
// ----------------------------------------------------------------------------
//
//   Port      Dir   Handshake     Contents
//   i_in      in    valid/ready   character, first_of_string
//   o_out     out   valid/ready   inhibited, is_separator, word_start,
//                                 word_total, target_hit, char_position
//   i_cfg_*   in    write enable  register index and 64-bit write data
//
// A word accepted on i_in lands in the input register; there the pair table
// and counters evaluate it and the result lands in the output register, and
// one word is taken every cycle while o_out does not stall.
// The scan state is updated in the same cycle that the result register loads.
// Reset is synchronous and active low; it clears the scan state, the
// configuration registers and both valid flags.
// When o_out stalls, the input register holds one more word and then i_in
// drops ready until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quote_aware_token_scanner
    import qats_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    qats_in_if.sink                    i_in,
    qats_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // Configuration registers.
    t_pair_chars        r_pair_open;
    t_pair_chars        r_pair_close;
    logic [PCNT_W-1:0]  r_pair_count;
    t_sep_chars         r_sep_chars;
    logic [PCNT_W-1:0]  r_sep_count;
    logic [CHAR_W-1:0]  r_target;

    // Scan state carried from one character to the next.
    t_depth_vec         r_depth;
    logic               r_esc_par;
    logic               r_prev_sep;
    logic [COUNT_W-1:0] r_word_cnt;
    logic [COUNT_W-1:0] r_pos_cnt;
    logic               r_target_seen;

    // Pipeline registers.
    logic               r_in_vld;
    t_in_item           r_in_data;
    logic               r_out_vld;
    t_out_item          r_out_data;

    logic               adv;
    logic               first;
    t_depth_vec         eff_depth;
    logic               eff_par;
    logic               eff_prev_sep;
    logic [COUNT_W-1:0] eff_word;
    logic [COUNT_W-1:0] eff_pos;
    logic               eff_seen;
    t_pair_res          pair_res;
    logic               sep;
    logic               ws;
    logic               hit;
    logic [COUNT_W-1:0] n_word_cnt;
    logic [COUNT_W-1:0] n_pos_cnt;
    logic               n_esc_par;
    t_out_item          n_out_data;

    // The stage advances when it holds a word and the result register is
    // free or being emptied this cycle.
    assign adv         = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || adv;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_data;

    // A first_of_string word sees a freshly cleared state.
    assign first        = r_in_data.first_of_string;
    assign eff_depth    = first ? '0 : r_depth;
    assign eff_par      = first ? 1'b0 : r_esc_par;
    assign eff_prev_sep = first ? 1'b1 : r_prev_sep;
    assign eff_word     = first ? '0 : r_word_cnt;
    assign eff_pos      = first ? '0 : r_pos_cnt;
    assign eff_seen     = first ? 1'b0 : r_target_seen;

    qats_pair_logic u_pairs (
        .i_char       (r_in_data.character),
        .i_escaped    (eff_par),
        .i_depth      (eff_depth),
        .i_open       (r_pair_open),
        .i_close      (r_pair_close),
        .i_pair_count (r_pair_count),
        .o_res        (pair_res)
    );

    // Separator membership ignores inhibition entirely.
    always_comb begin
        sep = 1'b0;
        for (int k = 0; k < MAX_SEPARATORS; k++) begin
            if ((r_sep_count > PCNT_W'(k)) && (r_sep_chars[k] == r_in_data.character)) begin
                sep = 1'b1;
            end
        end
    end

    always_comb begin
        ws         = !pair_res.inhibited && !sep && eff_prev_sep;
        hit        = !pair_res.inhibited && !eff_seen && (r_in_data.character == r_target);
        n_word_cnt = (ws && (eff_word != COUNT_MAX)) ? eff_word + COUNT_ONE : eff_word;
        n_pos_cnt  = (eff_pos != COUNT_MAX) ? eff_pos + COUNT_ONE : eff_pos;
        // Parity of the backslash run that ends at this character.
        n_esc_par  = (r_in_data.character == BACKSLASH) ? !eff_par : 1'b0;

        n_out_data.inhibited     = pair_res.inhibited;
        n_out_data.is_separator  = sep;
        n_out_data.word_start    = ws;
        n_out_data.word_total    = n_word_cnt;
        n_out_data.target_hit    = hit;
        n_out_data.char_position = eff_pos;
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_open  <= '0;
            r_pair_close <= '0;
            r_pair_count <= '0;
            r_sep_chars  <= '0;
            r_sep_count  <= '0;
            r_target     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAIR_OPEN:  r_pair_open  <= i_cfg_data;
                CFG_PAIR_CLOSE: r_pair_close <= i_cfg_data;
                CFG_PAIR_COUNT: r_pair_count <= i_cfg_data[PCNT_W-1:0];
                CFG_SEP_CHARS:  r_sep_chars  <= i_cfg_data;
                CFG_SEP_COUNT:  r_sep_count  <= i_cfg_data[PCNT_W-1:0];
                CFG_TARGET:     r_target     <= i_cfg_data[CHAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth       <= '0;
            r_esc_par     <= 1'b0;
            r_prev_sep    <= 1'b1;
            r_word_cnt    <= '0;
            r_pos_cnt     <= '0;
            r_target_seen <= 1'b0;
        end else if (adv) begin
            r_depth       <= pair_res.depth;
            r_esc_par     <= n_esc_par;
            r_prev_sep    <= sep;
            r_word_cnt    <= n_word_cnt;
            r_pos_cnt     <= n_pos_cnt;
            r_target_seen <= eff_seen || hit;
        end
    end

    // Input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data;
        end
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    // A new string always reports position zero.
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && first |=> o_out.data.char_position == '0)
        else $error("first character of a string not at position zero");

    // A held word must not be dropped while the result side stalls.
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in_data))
        else $error("input register lost a stalled word");

    // A word start is never inhibited and never a separator.
    a_word_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.word_start |->
            !o_out.data.inhibited && !o_out.data.is_separator)
        else $error("word start on an inhibited or separator character");

    // Only one target hit per string.
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_target_seen && !first |-> !hit)
        else $error("second target hit within one string");

endmodule

`default_nettype wire

@@ tb/quote_aware_token_scanner_test.sv @@
// ----------------------------------------------------------------------------
// quote_aware_token_scanner_test
// Self-checking bench for the quote-aware token scanner. Character words are
// fed through the input channel with random gaps. Result words are drained
// with random back-pressure. Every result is compared field by field against
// a cycle-free scanner model kept inside the bench.
// ----------------------------------------------------------------------------

module quote_aware_token_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qats_pkg::*;

    // Bench timing and pacing.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_PCT       = 14;
    localparam int REPORT_LINES   = 40;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_WORDS    = 110;

    // Saturation limits of the nesting depths and the running counters.
    localparam logic signed [DEPTH_W-1:0] DEPTH_TOP = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_BOT = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0]        COUNT_TOP = '1;

    // Register indexes that map to no register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // Characters used by the directed tests.
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;

    // Punctuation that random configurations draw their pair and separator
    // characters from, so that collisions between pairs are common.
    localparam logic [11:0][CHAR_W-1:0] PUNCT = {
        "\"", "'", "(", ")", "[", "]", "{", "}", " ", ",", "\\", "<"
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qats_in_if  in_ch ();
    qats_out_if out_ch ();

    quote_aware_token_scanner dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Scanner model state. The configuration copy follows every register
    // write seen on the configuration port; the scan state follows every
    // character word accepted on the input channel.
    // ------------------------------------------------------------------------
    t_pair_chars               open_tab;
    t_pair_chars               close_tab;
    t_sep_chars                sep_tab;
    logic [PCNT_W-1:0]         pairs_used;
    logic [PCNT_W-1:0]         seps_used;
    logic [CHAR_W-1:0]         target_ch;

    logic signed [DEPTH_W-1:0] nest_depth [MAX_PAIRS];
    logic                      esc_odd;
    logic                      last_was_sep;
    logic                      target_found;
    logic [COUNT_W-1:0]        words_seen;
    logic [COUNT_W-1:0]        chars_seen;

    // Result words predicted but not yet seen on the output channel, oldest
    // first.
    t_out_item                 results_due [$];

    int                        fail_count = 0;
    int                        quiet_cycles;

    // When set, neither side of the block idles.
    logic                      steady;

    // ------------------------------------------------------------------------
    // Scanner model.
    // ------------------------------------------------------------------------
    function automatic logic signed [DEPTH_W-1:0] depth_up(
        input logic signed [DEPTH_W-1:0] d
    );
        return (d == DEPTH_TOP) ? d : d + DEPTH_W'(1);
    endfunction

    function automatic logic signed [DEPTH_W-1:0] depth_down(
        input logic signed [DEPTH_W-1:0] d
    );
        return (d == DEPTH_BOT) ? d : d - DEPTH_W'(1);
    endfunction

    // The state after reset and at the start of every string is the same.
    function automatic void clear_string_state();
        int k;
        for (k = 0; k < MAX_PAIRS; k++) begin
            nest_depth[k] = '0;
        end
        esc_odd      = 1'b0;
        last_was_sep = 1'b1;
        target_found = 1'b0;
        words_seen   = '0;
        chars_seen   = '0;
    endfunction

    // Updates the nesting depths for one character and tells whether the
    // character lies inside an inhibited region.
    function automatic logic pair_scan(input logic [CHAR_W-1:0] c, input logic escaped);
        int                n;
        int                k;
        logic              opened;
        logic              closing;
        logic [CHAR_W-1:0] o;
        logic [CHAR_W-1:0] cl;
        n      = (pairs_used > MAX_PAIRS) ? MAX_PAIRS : pairs_used;
        opened = 1'b0;
        // While some region is open, only the first open pair sees the byte.
        for (k = 0; k < n; k++) begin
            if (nest_depth[k] != 0) begin
                o       = open_tab[k];
                cl      = close_tab[k];
                closing = 1'b0;
                if (o == c && o == cl && !escaped) begin
                    nest_depth[k] = '0;
                end else if (o == c) begin
                    nest_depth[k] = depth_up(nest_depth[k]);
                end else if (cl == c) begin
                    nest_depth[k] = depth_down(nest_depth[k]);
                    closing       = 1'b1;
                end
                return !(nest_depth[k] == 0 && !closing);
            end
        end
        // Nothing open: every pair in use reacts to the byte.
        for (k = 0; k < n; k++) begin
            o  = open_tab[k];
            cl = close_tab[k];
            if (o == c && o == cl && !escaped) begin
                nest_depth[k] = (nest_depth[k] == 0) ? DEPTH_W'(1) : '0;
                opened        = (nest_depth[k] != 0);
            end else if (o == c) begin
                nest_depth[k] = depth_up(nest_depth[k]);
                opened        = 1'b1;
            end else if (cl == c) begin
                nest_depth[k] = depth_down(nest_depth[k]);
            end
        end
        for (k = 0; k < n; k++) begin
            if (nest_depth[k] != 0 && (nest_depth[k] != 1 || !opened)) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the result word that one accepted character word causes.
    function automatic t_out_item scan_char(input t_in_item w);
        t_out_item r;
        logic      inh;
        logic      sep;
        logic      ws;
        logic      hit;
        int        ns;
        int        k;
        if (w.first_of_string) begin
            clear_string_state();
        end
        inh = pair_scan(w.character, esc_odd);
        ns  = (seps_used > MAX_SEPARATORS) ? MAX_SEPARATORS : seps_used;
        sep = 1'b0;
        for (k = 0; k < ns; k++) begin
            if (sep_tab[k] == w.character) begin
                sep = 1'b1;
            end
        end
        ws = !inh && !sep && last_was_sep;
        if (ws && words_seen != COUNT_TOP) begin
            words_seen = words_seen + 1'b1;
        end
        hit = !inh && !target_found && (w.character == target_ch);
        if (hit) begin
            target_found = 1'b1;
        end
        r.char_position = chars_seen;
        if (chars_seen != COUNT_TOP) begin
            chars_seen = chars_seen + 1'b1;
        end
        last_was_sep   = sep;
        esc_odd        = (w.character == BACKSLASH) ? !esc_odd : 1'b0;
        r.inhibited    = inh;
        r.is_separator = sep;
        r.word_start   = ws;
        r.word_total   = words_seen;
        r.target_hit   = hit;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        fail_count++;
        if (fail_count <= REPORT_LINES) begin
            $display("%0t ns mismatch on %s: expected %0d, got %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and the monitors. Inputs are driven at the falling edge;
    // everything below samples at the rising edge, before any register of
    // the block has taken its new value.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mirror of the configuration registers. Unknown indexes change nothing.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_tab   = '0;
            close_tab  = '0;
            sep_tab    = '0;
            pairs_used = '0;
            seps_used  = '0;
            target_ch  = '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAIR_OPEN:  open_tab   = i_cfg_data;
                CFG_PAIR_CLOSE: close_tab  = i_cfg_data;
                CFG_PAIR_COUNT: pairs_used = i_cfg_data[PCNT_W-1:0];
                CFG_SEP_CHARS:  sep_tab    = i_cfg_data;
                CFG_SEP_COUNT:  seps_used  = i_cfg_data[PCNT_W-1:0];
                CFG_TARGET:     target_ch  = i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Every accepted character word advances the model by one step.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string_state();
        end else if (in_ch.valid && in_ch.ready) begin
            results_due.push_back(scan_char(in_ch.data));
        end
    end

    // Every accepted result word is checked against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (results_due.size() == 0) begin
                flag_mismatch("result word with none pending", 0, 0);
            end else begin
                want = results_due.pop_front();
                if (got.inhibited !== want.inhibited) begin
                    flag_mismatch("inhibited", want.inhibited, got.inhibited);
                end
                if (got.is_separator !== want.is_separator) begin
                    flag_mismatch("is_separator", want.is_separator, got.is_separator);
                end
                if (got.word_start !== want.word_start) begin
                    flag_mismatch("word_start", want.word_start, got.word_start);
                end
                if (got.word_total !== want.word_total) begin
                    flag_mismatch("word_total", want.word_total, got.word_total);
                end
                if (got.target_hit !== want.target_hit) begin
                    flag_mismatch("target_hit", want.target_hit, got.target_hit);
                end
                if (got.char_position !== want.char_position) begin
                    flag_mismatch("char_position", want.char_position, got.char_position);
                end
            end
        end
    end

    // The run is stuck if no word moves on either channel for too long. The
    // longest legal silence is a drain plus one set of register writes.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Unless steady is set, the result side stalls in about 14 percent of cycles.
    always @(negedge i_clk) begin
        out_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Shared tasks.
    // ------------------------------------------------------------------------

    // Offers one character word and returns once it has been accepted. The
    // valid flag stays high afterwards, so back-to-back words need no gap.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic first);
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid                = 1'b1;
        in_ch.data.character       = c;
        in_ch.data.first_of_string = first;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    // Sends a whole string; its first character starts a new string.
    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_char(s[k], k == 0);
        end
    endtask

    // Lets every predicted result arrive and the pipeline empty out, so that
    // the registers can be rewritten safely.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Writes all six registers. The narrow ones get random junk above their
    // own bits, which the block must drop.
    task automatic load_config(input t_pair_chars opens, input t_pair_chars closes,
                               input logic [PCNT_W-1:0] pcount, input t_sep_chars seps,
                               input logic [PCNT_W-1:0] scount,
                               input logic [CHAR_W-1:0] tgt);
        logic [CFG_DATA_W-1:0] junk;
        set_reg(CFG_PAIR_OPEN, opens);
        set_reg(CFG_PAIR_CLOSE, closes);
        junk               = {$urandom, $urandom};
        junk[PCNT_W-1:0]   = pcount;
        set_reg(CFG_PAIR_COUNT, junk);
        set_reg(CFG_SEP_CHARS, seps);
        junk               = {$urandom, $urandom};
        junk[PCNT_W-1:0]   = scount;
        set_reg(CFG_SEP_COUNT, junk);
        junk               = {$urandom, $urandom};
        junk[CHAR_W-1:0]   = tgt;
        set_reg(CFG_TARGET, junk);
    endtask

    // Mostly punctuation, now and then any byte at all.
    function automatic logic [CHAR_W-1:0] pool_char();
        if ($urandom_range(99) < 80) begin
            return PUNCT[$urandom_range(11)];
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    // Random pair table in which about four pairs in ten are symmetric.
    task automatic random_config(input logic [PCNT_W-1:0] pcount,
                                 input logic [PCNT_W-1:0] scount);
        t_pair_chars opens;
        t_pair_chars closes;
        t_sep_chars  seps;
        int          k;
        for (k = 0; k < MAX_PAIRS; k++) begin
            opens[k]  = pool_char();
            closes[k] = ($urandom_range(99) < 40) ? opens[k] : pool_char();
            seps[k]   = pool_char();
        end
        load_config(opens, closes, pcount, seps, scount, pool_char());
    endtask

    // Random text biased toward the characters that the current table reacts
    // to, with plain letters and arbitrary bytes mixed in as noise.
    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        int k;
        roll = $urandom_range(99);
        k    = $urandom_range(MAX_PAIRS - 1);
        if (roll < 20) begin
            return open_tab[k];
        end else if (roll < 35) begin
            return close_tab[k];
        end else if (roll < 45) begin
            return BACKSLASH;
        end else if (roll < 60) begin
            return sep_tab[k];
        end else if (roll < 65) begin
            return target_ch;
        end else if (roll < 85) begin
            return CHAR_W'("a" + $urandom_range(25));
        end
        return CHAR_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Right after reset no pair and no separator is in use and the target is
    // the zero byte, so the first zero of each string is a hit and only the
    // first byte of a string starts a word.
    task automatic test_reset_state();
        send_char(8'h00, 1'b1);
        send_char(8'h00, 1'b0);
        send_char("a", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(BACKSLASH, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Quotes, nested brackets, escaped and doubly escaped quotes, a quote
    // inside another quote, a stray close bracket, and a target that is
    // hidden inside a region before it shows up outside one.
    task automatic test_quoting_rules();
        t_pair_chars opens;
        t_pair_chars closes;
        t_sep_chars  seps;
        wait_idle();
        set_reg(CFG_UNUSED_LO, {$urandom, $urandom});
        set_reg(CFG_UNUSED_HI, {$urandom, $urandom});
        opens     = '0;
        closes    = '0;
        seps      = '0;
        opens[0]  = CH_QUOTE;
        closes[0] = CH_QUOTE;
        opens[1]  = CH_LPAREN;
        closes[1] = CH_RPAREN;
        opens[2]  = CH_APOS;
        closes[2] = CH_APOS;
        opens[3]  = CH_LBRACK;
        closes[3] = CH_RBRACK;
        seps[0]   = CH_SPACE;
        seps[1]   = CH_COMMA;
        seps[2]   = CH_TAB;
        load_config(opens, closes, 4'd4, seps, 4'd3, CH_SEMI);
        send_text("\"x;\\\"y\" (a(b);) ; ;)(\\\\\"'\",w");
        send_text("\tab,,c [d] e");
    endtask

    // Nesting depths clip at both signed limits and recover from there.
    task automatic test_depth_limits();
        int k;
        for (k = 0; k < 260; k++) begin
            send_char(CH_LPAREN, k == 0);
        end
        repeat (3) send_char(CH_RPAREN, 1'b0);
        for (k = 0; k < 132; k++) begin
            send_char(CH_RPAREN, k == 0);
        end
        repeat (2) send_char(CH_LPAREN, 1'b0);
    endtask

    // Random text under a new register setting in every phase: a full table,
    // counts above the table size with all-ones characters, an empty table,
    // then random tables. The state is carried across each rewrite, which
    // also covers a change of setting in the middle of a string. One phase
    // runs with neither side idling.
    task automatic test_random_text();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: random_config(4'd8, 4'd8);
                1: load_config('1, '1, 4'd15, '1, 4'd15, 8'hFF);
                2: load_config('0, '0, 4'd0, '0, 4'd0, 8'h00);
                default: random_config(PCNT_W'($urandom_range(15)),
                                       PCNT_W'($urandom_range(15)));
            endcase
            steady = (phase == 3);
            for (n = 0; n < PHASE_WORDS; n++) begin
                send_char(pick_char(), $urandom_range(99) < 3);
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_PAIR_OPEN;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        steady       = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_quoting_rules();
        test_depth_limits();
        test_random_text();

        // Everything has been sent; let the last results come out and give
        // the block a further drain to show any stray result word.
        wait_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ quote_aware_token_scanner.f @@
sv/qats_pkg.sv
sv/qats_in_if.sv
sv/qats_out_if.sv
sv/qats_pair_logic.sv
sv/quote_aware_token_scanner.sv
tb/quote_aware_token_scanner_test.sv
